// File: rtl/sfc_pkg.sv
// Shared constants and types for the stereo FIR convolver.
// No dependencies; compile first.
`default_nettype none

package sfc_pkg;

   localparam int SFC_MAX_TAPS    = 1024;
   localparam int SFC_SAMPLE_BITS = 24;
   localparam int SFC_INDEX_BITS  = 10;
   localparam int SFC_COUNT_BITS  = 11;
   localparam int SFC_ACC_BITS    = 64;

   typedef enum logic {
      SFC_OP_SAMPLE = 1'b0,
      SFC_OP_LOAD   = 1'b1
   } sfc_opcode_type;

   // sequencer to MAC unit
   typedef struct packed {
      logic start;
      logic issue;
      logic finish;
   } sfc_mac_ctl_type;

   // MAC unit back to sequencer
   typedef struct packed {
      logic idle;
      logic done;
   } sfc_mac_status_type;

endpackage

`default_nettype wire

// File: rtl/sfc_req_if.sv
// Request channel: sample or coefficient-load items.
// Depends on sfc_pkg.
`default_nettype none

interface sfc_req_if #(
   parameter int SAMPLE_BITS = sfc_pkg::SFC_SAMPLE_BITS
) ();
   import sfc_pkg::*;

   logic                          valid;
   logic                          ready;
   logic                          opcode;
   logic [SFC_INDEX_BITS-1:0]     coef_index;
   logic signed [SAMPLE_BITS-1:0] coef_left;
   logic signed [SAMPLE_BITS-1:0] coef_right;
   logic signed [SAMPLE_BITS-1:0] sample_left;
   logic signed [SAMPLE_BITS-1:0] sample_right;

   modport source (
      output valid, opcode, coef_index, coef_left, coef_right, sample_left, sample_right,
      input  ready
   );
   modport sink (
      input  valid, opcode, coef_index, coef_left, coef_right, sample_left, sample_right,
      output ready
   );
endinterface

`default_nettype wire

// File: rtl/sfc_rsp_if.sv
// Response channel: one stereo convolution result per sample item.
// Depends on sfc_pkg.
`default_nettype none

interface sfc_rsp_if #(
   parameter int SAMPLE_BITS = sfc_pkg::SFC_SAMPLE_BITS
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] out_left;
   logic signed [SAMPLE_BITS-1:0] out_right;

   modport source (output valid, out_left, out_right, input ready);
   modport sink   (input valid, out_left, out_right, output ready);
endinterface

`default_nettype wire

// File: rtl/sfc_csr_if.sv
// Configuration write channel carrying the tap count register.
// Depends on sfc_pkg.
`default_nettype none

interface sfc_csr_if ();
   import sfc_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [SFC_COUNT_BITS-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// File: rtl/sfc_store.sv
// History and coefficient memories for both channels, one write and one
// registered read port per memory. Depends on sfc_pkg.
`default_nettype none

module sfc_store #(
   parameter int MAX_TAPS    = sfc_pkg::SFC_MAX_TAPS,
   parameter int SAMPLE_BITS = sfc_pkg::SFC_SAMPLE_BITS,
   parameter int ADDR_BITS   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
   input  wire logic                   clock,
   input  wire logic                   hist_we,
   input  wire logic [ADDR_BITS-1:0]   hist_waddr,
   input  wire logic [SAMPLE_BITS-1:0] hist_wdata_left,
   input  wire logic [SAMPLE_BITS-1:0] hist_wdata_right,
   input  wire logic                   tap_we,
   input  wire logic [ADDR_BITS-1:0]   tap_waddr,
   input  wire logic [SAMPLE_BITS-1:0] tap_wdata_left,
   input  wire logic [SAMPLE_BITS-1:0] tap_wdata_right,
   input  wire logic [ADDR_BITS-1:0]   hist_raddr,
   input  wire logic [ADDR_BITS-1:0]   tap_raddr,
   output logic      [SAMPLE_BITS-1:0] hist_rdata_left,
   output logic      [SAMPLE_BITS-1:0] hist_rdata_right,
   output logic      [SAMPLE_BITS-1:0] tap_rdata_left,
   output logic      [SAMPLE_BITS-1:0] tap_rdata_right
);
   import sfc_pkg::*;

   logic [SAMPLE_BITS-1:0] hist_left_mem  [MAX_TAPS];
   logic [SAMPLE_BITS-1:0] hist_right_mem [MAX_TAPS];
   logic [SAMPLE_BITS-1:0] tap_left_mem   [MAX_TAPS];
   logic [SAMPLE_BITS-1:0] tap_right_mem  [MAX_TAPS];

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_left_mem[hist_waddr]  <= hist_wdata_left;
         hist_right_mem[hist_waddr] <= hist_wdata_right;
      end
      hist_rdata_left  <= hist_left_mem[hist_raddr];
      hist_rdata_right <= hist_right_mem[hist_raddr];
   end

   always_ff @(posedge clock) begin
      if (tap_we) begin
         tap_left_mem[tap_waddr]  <= tap_wdata_left;
         tap_right_mem[tap_waddr] <= tap_wdata_right;
      end
      tap_rdata_left  <= tap_left_mem[tap_raddr];
      tap_rdata_right <= tap_right_mem[tap_raddr];
   end

endmodule

`default_nettype wire

// File: rtl/sfc_mac.sv
// Shared multiply-accumulate unit for both channels: registered products,
// saturating 64-bit accumulators, rounding and output saturation. Depends on sfc_pkg.
`default_nettype none

module sfc_mac #(
   parameter int SAMPLE_BITS = sfc_pkg::SFC_SAMPLE_BITS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire sfc_pkg::sfc_mac_ctl_type        ctl,
   input  wire logic [SAMPLE_BITS-1:0]          hist_left,
   input  wire logic [SAMPLE_BITS-1:0]          hist_right,
   input  wire logic [SAMPLE_BITS-1:0]          tap_left,
   input  wire logic [SAMPLE_BITS-1:0]          tap_right,
   output sfc_pkg::sfc_mac_status_type          status,
   output logic      [SAMPLE_BITS-1:0]          out_left,
   output logic      [SAMPLE_BITS-1:0]          out_right
);
   import sfc_pkg::*;

   localparam int ACC  = SFC_ACC_BITS;
   localparam int PW   = 2 * SAMPLE_BITS;
   localparam int UW   = ACC - SAMPLE_BITS + 1;
   localparam logic signed [ACC-1:0] HALF = ACC'(1) << (SAMPLE_BITS - 2);

   function automatic logic signed [ACC-1:0] sat_add(
      input logic signed [ACC-1:0] a,
      input logic signed [ACC-1:0] b
   );
      logic [ACC:0] sum;
      sum = {a[ACC-1], a} + {b[ACC-1], b};
      if (sum[ACC] != sum[ACC-1]) begin
         sat_add = sum[ACC] ? {1'b1, {(ACC-1){1'b0}}} : {1'b0, {(ACC-1){1'b1}}};
      end else begin
         sat_add = sum[ACC-1:0];
      end
   endfunction

   // floor shift to the sample format, then clamp to its range
   function automatic logic [SAMPLE_BITS-1:0] narrow(input logic signed [ACC-1:0] acc);
      logic signed [ACC-1:0] q;
      logic        [UW-1:0]  upper;
      q     = acc >>> (SAMPLE_BITS - 1);
      upper = q[ACC-1:SAMPLE_BITS-1];
      if ((&upper) || !(|upper)) begin
         narrow = q[SAMPLE_BITS-1:0];
      end else begin
         narrow = q[ACC-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                           : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
   endfunction

   logic                  rd_valid_ff, prod_valid_ff, rnd_valid_ff, done_ff;
   logic signed [PW-1:0]  prod_left_ff, prod_right_ff;
   logic signed [PW-1:0]  prod_left_in, prod_right_in;
   logic signed [ACC-1:0] acc_left_ff, acc_right_ff;
   logic signed [ACC-1:0] acc_left_in, acc_right_in;
   logic signed [ACC-1:0] rnd_left_ff, rnd_right_ff;

   assign prod_left_in  = $signed(hist_left)  * $signed(tap_left);
   assign prod_right_in = $signed(hist_right) * $signed(tap_right);

   always_comb begin
      acc_left_in  = acc_left_ff;
      acc_right_in = acc_right_ff;
      if (ctl.start) begin
         acc_left_in  = '0;
         acc_right_in = '0;
      end else if (prod_valid_ff) begin
         acc_left_in  = sat_add(acc_left_ff, ACC'(prod_left_ff));
         acc_right_in = sat_add(acc_right_ff, ACC'(prod_right_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
         rnd_valid_ff  <= 1'b0;
         done_ff       <= 1'b0;
      end else begin
         rd_valid_ff   <= ctl.issue;
         prod_valid_ff <= rd_valid_ff;
         rnd_valid_ff  <= ctl.finish;
         done_ff       <= rnd_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_left_ff  <= prod_left_in;
      prod_right_ff <= prod_right_in;
      acc_left_ff   <= acc_left_in;
      acc_right_ff  <= acc_right_in;
      if (ctl.finish) begin
         rnd_left_ff  <= sat_add(acc_left_ff, HALF);
         rnd_right_ff <= sat_add(acc_right_ff, HALF);
      end
      if (rnd_valid_ff) begin
         out_left  <= narrow(rnd_left_ff);
         out_right <= narrow(rnd_right_ff);
      end
   end

   assign status.idle = !rd_valid_ff && !prod_valid_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

// File: rtl/stereo_fir_convolver.sv
// Stereo direct-form FIR convolver.
// Channels: req_ch takes items (opcode selects a coefficient-pair load or a
// stereo sample), rsp_ch gives one saturated stereo result per sample item,
// csr_ch writes the tap count (always ready; write only while idle).
// A load gives no result. For a sample item the history is written at the
// transfer, then one tap per cycle goes through the shared multiply-accumulate
// unit (one memory read port per store), then follow pipeline drain, rounding
// and saturation, and the load of the result register. req_ch is not ready while
// a sample is being processed and takes the next item the cycle after the result
// is loaded. The result sits in an output register; a new item is taken while it
// waits, and a sample only stalls at its end if the previous result is still
// there. After reset a clearing pass over all MAX_TAPS addresses zeroes history
// and coefficients; req_ch is held not ready during it. Tap count resets to 0.
// Depends on sfc_pkg, sfc_req_if, sfc_rsp_if, sfc_csr_if, sfc_store, sfc_mac.
`default_nettype none

module stereo_fir_convolver #(
   parameter int MAX_TAPS    = sfc_pkg::SFC_MAX_TAPS,
   parameter int SAMPLE_BITS = sfc_pkg::SFC_SAMPLE_BITS
) (
   input wire logic  clock,
   input wire logic  reset,
   sfc_req_if.sink   req_ch,
   sfc_rsp_if.source rsp_ch,
   sfc_csr_if.sink   csr_ch
);
   import sfc_pkg::*;

   localparam int AW  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int CW  = $clog2(MAX_TAPS + 1);
   localparam int NW  = (CW > SFC_COUNT_BITS) ? CW : SFC_COUNT_BITS;
   localparam int IXW = (CW > SFC_INDEX_BITS) ? CW : SFC_INDEX_BITS;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_RUN   = 6'b000100,
      ST_DRAIN = 6'b001000,
      ST_ROUND = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   state_type                 state_ff, state_in;
   logic [AW-1:0]             clr_ff, clr_in;
   logic [AW-1:0]             wp_ff, wp_in;
   logic [AW-1:0]             pos_ff, pos_in;
   logic [AW-1:0]             tap_ff, tap_in;
   logic [SFC_COUNT_BITS-1:0] tap_count_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0]    rsp_left_ff, rsp_left_in;
   logic [SAMPLE_BITS-1:0]    rsp_right_ff, rsp_right_in;

   logic [NW-1:0]             tc_wide, n_wide;
   logic [CW-1:0]             n;
   logic [AW-1:0]             wp_eff, wp_next;
   logic [CW-1:0]             wp_inc;
   logic                      idx_ok, req_fire;

   logic                      hist_we, tap_we;
   logic [AW-1:0]             hist_waddr, tap_waddr;
   logic [SAMPLE_BITS-1:0]    hist_wl, hist_wr, tap_wl, tap_wr;
   logic [SAMPLE_BITS-1:0]    hist_rl, hist_rr, tap_rl, tap_rr;
   logic [SAMPLE_BITS-1:0]    mac_left, mac_right;
   sfc_mac_ctl_type           mac_ctl;
   sfc_mac_status_type        mac_status;

   // taps in use, capped at the store depth
   assign tc_wide = NW'(tap_count_ff);
   assign n_wide  = (tc_wide > NW'(MAX_TAPS)) ? NW'(MAX_TAPS) : tc_wide;
   assign n       = CW'(n_wide);

   assign wp_eff  = (CW'(wp_ff) >= n) ? '0 : wp_ff;
   assign wp_inc  = CW'(wp_ff) + CW'(1);
   assign wp_next = (wp_inc >= n) ? '0 : AW'(wp_inc);
   assign idx_ok  = IXW'(req_ch.coef_index) < IXW'(MAX_TAPS);

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      wp_in        = wp_ff;
      pos_in       = pos_ff;
      tap_in       = tap_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      hist_we      = 1'b0;
      hist_waddr   = wp_eff;
      hist_wl      = req_ch.sample_left;
      hist_wr      = req_ch.sample_right;
      tap_we       = 1'b0;
      tap_waddr    = AW'(req_ch.coef_index);
      tap_wl       = req_ch.coef_left;
      tap_wr       = req_ch.coef_right;
      mac_ctl      = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            hist_we    = 1'b1;
            hist_waddr = clr_ff;
            hist_wl    = '0;
            hist_wr    = '0;
            tap_we     = 1'b1;
            tap_waddr  = clr_ff;
            tap_wl     = '0;
            tap_wr     = '0;
            if (CW'(clr_ff) == CW'(MAX_TAPS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_ch.opcode)
                  SFC_OP_LOAD: begin
                     tap_we = idx_ok;
                  end
                  SFC_OP_SAMPLE: begin
                     hist_we       = 1'b1;
                     wp_in         = wp_eff;
                     pos_in        = wp_eff;
                     tap_in        = '0;
                     mac_ctl.start = 1'b1;
                     state_in      = (n == '0) ? ST_DRAIN : ST_RUN;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_RUN: begin
            mac_ctl.issue = 1'b1;
            if (CW'(tap_ff) == n - CW'(1)) begin
               state_in = ST_DRAIN;
            end else begin
               tap_in = tap_ff + AW'(1);
               pos_in = (pos_ff == '0) ? AW'(n - CW'(1)) : pos_ff - AW'(1);
            end
         end
         ST_DRAIN: begin
            if (mac_status.idle) begin
               mac_ctl.finish = 1'b1;
               state_in       = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (mac_status.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_left_in  = mac_left;
               rsp_right_in = mac_right;
               wp_in        = wp_next;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         wp_ff        <= '0;
         tap_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         wp_ff        <= wp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_ch.valid && csr_ch.ready) begin
            tap_count_ff <= csr_ch.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      tap_ff       <= tap_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.out_left  = rsp_left_ff;
   assign rsp_ch.out_right = rsp_right_ff;

   sfc_store #(
      .MAX_TAPS    (MAX_TAPS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .ADDR_BITS   (AW)
   ) u_store (
      .clock            (clock),
      .hist_we          (hist_we),
      .hist_waddr       (hist_waddr),
      .hist_wdata_left  (hist_wl),
      .hist_wdata_right (hist_wr),
      .tap_we           (tap_we),
      .tap_waddr        (tap_waddr),
      .tap_wdata_left   (tap_wl),
      .tap_wdata_right  (tap_wr),
      .hist_raddr       (pos_ff),
      .tap_raddr        (tap_ff),
      .hist_rdata_left  (hist_rl),
      .hist_rdata_right (hist_rr),
      .tap_rdata_left   (tap_rl),
      .tap_rdata_right  (tap_rr)
   );

   sfc_mac #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_mac (
      .clock      (clock),
      .reset      (reset),
      .ctl        (mac_ctl),
      .hist_left  (hist_rl),
      .hist_right (hist_rr),
      .tap_left   (tap_rl),
      .tap_right  (tap_rr),
      .status     (mac_status),
      .out_left   (mac_left),
      .out_right  (mac_right)
   );

endmodule

`default_nettype wire

// File: tb/sv/tb_stereo_fir_convolver.sv
// Self-checking testbench for stereo_fir_convolver: directed table, then random phases
// over several tap counts, checked by an in-bench convolution predictor or known values.
// Depends on sfc_pkg, sfc_req_if, sfc_rsp_if, sfc_csr_if and the convolver RTL.
`default_nettype none

module tb_stereo_fir_convolver;
   timeunit 1ns;
   timeprecision 1ps;
   import sfc_pkg::*;

   localparam int SB             = SFC_SAMPLE_BITS;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES    = 3000;
   localparam int HOLD_AFTER     = 240;
   localparam int NUM_PHASES     = 11;
   localparam int NUM_ROWS       = 24;

   typedef struct packed {
      sfc_opcode_type            op;
      logic [SFC_INDEX_BITS-1:0] coef_index;
      logic signed [SB-1:0]      coef_left;
      logic signed [SB-1:0]      coef_right;
      logic signed [SB-1:0]      sample_left;
      logic signed [SB-1:0]      sample_right;
   } fir_item_type;

   typedef struct packed {
      logic signed [SB-1:0] left;
      logic signed [SB-1:0] right;
   } stereo_pair_type;

   typedef enum logic {
      ROW_SET_TAPS = 1'b0,
      ROW_ITEM     = 1'b1
   } row_kind_type;

   typedef struct packed {
      row_kind_type              kind;
      logic [SFC_COUNT_BITS-1:0] taps;
      fir_item_type              item;
      logic                      typed;
      stereo_pair_type           known;
   } directed_row_type;

   logic clock;
   logic reset;

   sfc_req_if req_bus ();
   sfc_rsp_if rsp_bus ();
   sfc_csr_if csr_bus ();

   stereo_fir_convolver dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // predictor state
   logic [SFC_COUNT_BITS-1:0] tap_setting;
   logic signed [SB-1:0]      hist_l [SFC_MAX_TAPS];
   logic signed [SB-1:0]      hist_r [SFC_MAX_TAPS];
   logic signed [SB-1:0]      coef_l [SFC_MAX_TAPS];
   logic signed [SB-1:0]      coef_r [SFC_MAX_TAPS];
   int unsigned               slot;

   stereo_pair_type pending_results [$];
   int              fail_count = 0;
   int              items_sent;
   int              idle_cycles = 0;
   logic            req_burst;
   logic            rsp_burst;
   logic            rsp_hold;

   int phase_taps  [NUM_PHASES] = '{5, 0, 1024, 2, 16, 2047, 1, 64, 7, 300, 3};
   int phase_items [NUM_PHASES] = '{100, 20, 8, 60, 100, 6, 40, 80, 90, 16, 60};

   directed_row_type directed_rows [NUM_ROWS] = '{
      // tap count 0 after reset: history written, result zero
      '{ROW_ITEM, 11'd0, '{SFC_OP_SAMPLE, 10'd0, 24'h000000, 24'h000000,
         24'h7FFFFF, 24'h800000}, 1'b1, '{24'h000000, 24'h000000}},
      '{ROW_ITEM, 11'd0, '{SFC_OP_SAMPLE, 10'h3FF, 24'hFFFFFF, 24'hFFFFFF,
         24'h800000, 24'h7FFFFF}, 1'b1, '{24'h000000, 24'h000000}},
      '{ROW_SET_TAPS, 11'd1, '0, 1'b0, '0},
      '{ROW_ITEM, 11'd0, '{SFC_OP_LOAD, 10'd0, 24'h7FFFFF, 24'h800000,
         24'h555555, 24'hAAAAAA}, 1'b0, '0},
      '{ROW_ITEM, 11'd0, '{SFC_OP_SAMPLE, 10'd0, 24'h000000, 24'h000000,
         24'h7FFFFF, 24'h7FFFFF}, 1'b1, '{24'h7FFFFE, 24'h800001}},
      // most negative squared on the right: saturate high
      '{ROW_ITEM, 11'd0, '{SFC_OP_SAMPLE, 10'd0, 24'h000000, 24'h000000,
         24'h800000, 24'h800000}, 1'b1, '{24'h800001, 24'h7FFFFF}},
      '{ROW_ITEM, 11'd0, '{SFC_OP_SAMPLE, 10'd0, 24'h000000, 24'h000000,
         24'h000000, 24'h000000}, 1'b1, '{24'h000000, 24'h000000}},
      '{ROW_ITEM, 11'd0, '{SFC_OP_LOAD, 10'd0, 24'h800000, 24'h800000,
         24'h000000, 24'h000000}, 1'b0, '0},
      '{ROW_ITEM, 11'd0, '{SFC_OP_SAMPLE, 10'd0, 24'h000000, 24'h000000,
         24'h800000, 24'h7FFFFF}, 1'b1, '{24'h7FFFFF, 24'h800001}},
      // half coefficient: exact half LSB rounds up
      '{ROW_ITEM, 11'd0, '{SFC_OP_LOAD, 10'd0, 24'h400000, 24'h400000,
         24'h000000, 24'h000000}, 1'b0, '0},
      '{ROW_ITEM, 11'd0, '{SFC_OP_SAMPLE, 10'd0, 24'h000000, 24'h000000,
         24'h000001, 24'hFFFFFF}, 1'b1, '{24'h000001, 24'h000000}},
      '{ROW_ITEM, 11'd0, '{SFC_OP_LOAD, 10'h3FF, 24'hAAAAAA, 24'h555555,
         24'h000000, 24'h000000}, 1'b0, '0},
      '{ROW_SET_TAPS, 11'd3, '0, 1'b0, '0},
      '{ROW_ITEM, 11'd0, '{SFC_OP_LOAD, 10'd1, 24'h123456, 24'hFEDCBA,
         24'h000000, 24'h000000}, 1'b0, '0},
      '{ROW_ITEM, 11'd0, '{SFC_OP_LOAD, 10'd2, 24'h800000, 24'h7FFFFF,
         24'h000000, 24'h000000}, 1'b0, '0},
      '{ROW_ITEM, 11'd0, '{SFC_OP_SAMPLE, 10'd0, 24'h000000, 24'h000000,
         24'h345678, 24'hCBA987}, 1'b0, '0},
      '{ROW_ITEM, 11'd0, '{SFC_OP_SAMPLE, 10'd0, 24'h000000, 24'h000000,
         24'h7FFFFF, 24'h800000}, 1'b0, '0},
      // pointer now 2: lowering the count to 2 restarts it at 0
      '{ROW_SET_TAPS, 11'd2, '0, 1'b0, '0},
      '{ROW_ITEM, 11'd0, '{SFC_OP_SAMPLE, 10'd0, 24'h000000, 24'h000000,
         24'h000100, 24'hFFFF00}, 1'b0, '0},
      '{ROW_ITEM, 11'd0, '{SFC_OP_SAMPLE, 10'd0, 24'h000000, 24'h000000,
         24'h400000, 24'hC00000}, 1'b0, '0},
      // count above the store size acts as the full store
      '{ROW_SET_TAPS, 11'd2047, '0, 1'b0, '0},
      '{ROW_ITEM, 11'd0, '{SFC_OP_LOAD, 10'h3FF, 24'h7FFFFF, 24'h800000,
         24'h000000, 24'h000000}, 1'b0, '0},
      '{ROW_ITEM, 11'd0, '{SFC_OP_SAMPLE, 10'd0, 24'h000000, 24'h000000,
         24'h7FFFFF, 24'h7FFFFF}, 1'b0, '0},
      '{ROW_ITEM, 11'd0, '{SFC_OP_SAMPLE, 10'd0, 24'h000000, 24'h000000,
         24'h800000, 24'h000001}, 1'b0, '0}
   };

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
   endfunction

   // round half up to the sample grid, then clamp to the sample range
   function automatic logic signed [SB-1:0] round_to_sample(input longint acc);
      longint q;
      q = (acc + (longint'(1) <<< (SB - 2))) >>> (SB - 1);
      if (q > (longint'(1) <<< (SB - 1)) - 1) q = (longint'(1) <<< (SB - 1)) - 1;
      if (q < -(longint'(1) <<< (SB - 1))) q = -(longint'(1) <<< (SB - 1));
      return q[SB-1:0];
   endfunction

   // update the filter state for one item; return 1 when it yields a result
   function automatic bit convolve_item(input fir_item_type it, output stereo_pair_type res);
      int unsigned n;
      int unsigned pos;
      longint      sum_l;
      longint      sum_r;
      res = '0;
      if (it.op == SFC_OP_LOAD) begin
         coef_l[it.coef_index] = it.coef_left;
         coef_r[it.coef_index] = it.coef_right;
         return 1'b0;
      end
      n = (tap_setting > SFC_MAX_TAPS) ? SFC_MAX_TAPS : tap_setting;
      if (slot >= n) slot = 0;
      hist_l[slot] = it.sample_left;
      hist_r[slot] = it.sample_right;
      pos   = slot;
      sum_l = 0;
      sum_r = 0;
      for (int i = 0; i < n; i++) begin
         sum_l += longint'(hist_l[pos]) * longint'(coef_l[i]);
         sum_r += longint'(hist_r[pos]) * longint'(coef_r[i]);
         pos = (pos == 0) ? n - 1 : pos - 1;
      end
      res.left  = round_to_sample(sum_l);
      res.right = round_to_sample(sum_r);
      slot++;
      if (slot >= n) slot = 0;
      return 1'b1;
   endfunction

   function automatic logic [SB-1:0] random_word();
      logic [31:0] r;
      r = $urandom();
      case ($urandom_range(0, 9))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return 24'h000000;
         3, 4: return {{12{r[11]}}, r[11:0]};
         default: return r[SB-1:0];
      endcase
   endfunction

   function automatic fir_item_type random_item(input int unsigned taps);
      fir_item_type it;
      int unsigned  n;
      n               = (taps > SFC_MAX_TAPS) ? SFC_MAX_TAPS : taps;
      it.op           = ($urandom_range(0, 99) < 35) ? SFC_OP_LOAD : SFC_OP_SAMPLE;
      it.coef_index   = SFC_INDEX_BITS'((n > 0 && $urandom_range(0, 3) != 0) ?
                        $urandom_range(0, n - 1) : $urandom_range(0, SFC_MAX_TAPS - 1));
      it.coef_left    = random_word();
      it.coef_right   = random_word();
      it.sample_left  = random_word();
      it.sample_right = random_word();
      return it;
   endfunction

   task automatic send_item(input fir_item_type it, input bit typed,
                            input stereo_pair_type known);
      int              gap;
      stereo_pair_type res;
      gap = req_burst ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.opcode       <= it.op;
      req_bus.coef_index   <= it.coef_index;
      req_bus.coef_left    <= it.coef_left;
      req_bus.coef_right   <= it.coef_right;
      req_bus.sample_left  <= it.sample_left;
      req_bus.sample_right <= it.sample_right;
      do @(posedge clock); while (!req_bus.ready);
      if (convolve_item(it, res)) pending_results.push_back(typed ? known : res);
      items_sent++;
   endtask

   // drop valid, wait for every result, then let a trailing load finish
   task automatic drain_block();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_tap_count(input logic [SFC_COUNT_BITS-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      tap_setting = value;
   endtask

   // result side: random stalls, a long hold on request, check every transfer
   initial begin
      int              stall;
      stereo_pair_type want;
      rsp_bus.ready <= 1'b0;
      forever begin
         stall = rsp_burst ? 0 : $urandom_range(0, 13);
         if (stall > 0 || rsp_hold) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
            while (rsp_hold) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
         if (pending_results.size() == 0) begin
            note_failure($sformatf("result %h/%h with none pending",
                                   rsp_bus.out_left, rsp_bus.out_right));
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.out_left !== want.left)
               note_failure($sformatf("out_left: expected %h, got %h",
                                      want.left, rsp_bus.out_left));
            if (rsp_bus.out_right !== want.right)
               note_failure($sformatf("out_right: expected %h, got %h",
                                      want.right, rsp_bus.out_right));
         end
      end
   end

   // hold off the result side long enough to back up the request side
   initial begin
      rsp_hold <= 1'b0;
      wait (items_sent >= HOLD_AFTER);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", idle_cycles);
         $display("tb_stereo_fir_convolver NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      items_sent  = 0;
      tap_setting = '0;
      slot        = 0;
      foreach (hist_l[i]) begin
         hist_l[i] = '0;
         hist_r[i] = '0;
         coef_l[i] = '0;
         coef_r[i] = '0;
      end
      req_burst            <= 1'b0;
      rsp_burst            <= 1'b0;
      req_bus.valid        <= 1'b0;
      req_bus.opcode       <= SFC_OP_SAMPLE;
      req_bus.coef_index   <= '0;
      req_bus.coef_left    <= '0;
      req_bus.coef_right   <= '0;
      req_bus.sample_left  <= '0;
      req_bus.sample_right <= '0;
      csr_bus.valid        <= 1'b0;
      csr_bus.data         <= '0;
      reset                <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_SET_TAPS) begin
            drain_block();
            write_tap_count(directed_rows[r].taps);
         end else begin
            send_item(directed_rows[r].item, directed_rows[r].typed,
                      directed_rows[r].known);
         end
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         drain_block();
         write_tap_count(SFC_COUNT_BITS'(phase_taps[p]));
         req_burst <= ($urandom_range(0, 3) == 0);
         rsp_burst <= ($urandom_range(0, 3) == 0);
         repeat (phase_items[p]) send_item(random_item(phase_taps[p]), 1'b0, '0);
      end

      drain_block();
      repeat (64) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_stereo_fir_convolver OK");
      end else begin
         $display("tb_stereo_fir_convolver NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire
